/* design/bctu_pkg.sv */
// Shared types, codes and helper functions of the branch/call/trap unit.
`timescale 1ns / 1ps

package bctu_pkg;

  localparam int BCTU_STACK_BYTES = 1024;

  localparam logic [15:0] FLAG_N = 16'h8000;
  localparam logic [15:0] FLAG_Z = 16'h4000;
  localparam logic [15:0] FLAG_C = 16'h2000;
  localparam logic [15:0] FLAG_O = 16'h1000;

  typedef enum logic [3:0] {
    REQ_SET_STATUS = 4'd0,
    REQ_SET_SP     = 4'd1,
    REQ_JMP        = 4'd2,
    REQ_JSR        = 4'd3,
    REQ_RET        = 4'd4,
    REQ_BR         = 4'd5,
    REQ_BRN        = 4'd6,
    REQ_BRZ        = 4'd7,
    REQ_BRC        = 4'd8,
    REQ_BRO        = 4'd9,
    REQ_TRAP_PUSH  = 4'd10,
    REQ_TRAP_POP   = 4'd11
  } req_t;

  // stack operations run by the sequencer
  typedef enum logic [1:0] {
    MOP_JSR,
    MOP_RET,
    MOP_PUSH,
    MOP_POP
  } mop_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MEM,
    ST_LAST
  } seq_state_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] sw;
    logic [15:0] sp;
  } rsp_t;

  typedef struct packed {
    logic push;
    rsp_t data;
  } outq_wr_t;

  function automatic mop_t mop_of(input req_t req);
    mop_t m;
    case (req)
      REQ_RET:       m = MOP_RET;
      REQ_TRAP_PUSH: m = MOP_PUSH;
      REQ_TRAP_POP:  m = MOP_POP;
      default:       m = MOP_JSR;
    endcase
    return m;
  endfunction

  // byte offset from the starting SP for each access of an operation
  function automatic logic [15:0] mop_offset(input mop_t m, input logic [1:0] step);
    logic [15:0] off;
    case (m)
      MOP_RET: off = 16'd2 + {14'd0, step};
      MOP_POP: off = 16'd2 + {14'd0, step};
      MOP_PUSH: begin
        case (step)
          2'd0:    off = 16'h0000;
          2'd1:    off = 16'h0001;
          2'd2:    off = 16'hFFFE;
          default: off = 16'hFFFF;
        endcase
      end
      default: off = {14'd0, step};
    endcase
    return off;
  endfunction

  function automatic logic [15:0] mop_sp_delta(input mop_t m);
    logic [15:0] d;
    case (m)
      MOP_RET:  d = 16'h0002;
      MOP_PUSH: d = 16'hFFFC;
      MOP_POP:  d = 16'h0004;
      default:  d = 16'hFFFE;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] mop_last(input mop_t m);
    return (m == MOP_PUSH || m == MOP_POP) ? 2'd3 : 2'd1;
  endfunction

  function automatic logic mop_writes(input mop_t m);
    return (m == MOP_JSR || m == MOP_PUSH);
  endfunction

endpackage

/* design/bctu_if.sv */
// Request and response channel interfaces of the branch/call/trap unit.
`timescale 1ns / 1ps

interface bctu_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         req_type;
  logic [15:0]        target_address;
  logic signed [15:0] branch_offset;

  modport source (output valid, req_type, target_address, branch_offset, input ready);
  modport sink   (input valid, req_type, target_address, branch_offset, output ready);
endinterface

interface bctu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] program_counter_out;
  logic [15:0] status_word_out;
  logic [15:0] stack_pointer_out;

  modport source (output valid, program_counter_out, status_word_out, stack_pointer_out,
                  input ready);
  modport sink   (input valid, program_counter_out, status_word_out, stack_pointer_out,
                  output ready);
endinterface

/* design/bctu_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module bctu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/bctu_slot.sv */
// Byte address to stack slot: address modulo the stack size, with the quotient registered.
`timescale 1ns / 1ps

module bctu_slot import bctu_pkg::*; #(
  parameter int STACK_BYTES = BCTU_STACK_BYTES
) (
  input  logic                           clk,
  input  logic [15:0]                    addr,
  output logic [$clog2(STACK_BYTES)-1:0] slot
);

  localparam int          AW    = $clog2(STACK_BYTES);
  localparam int          SH    = 16 + AW;
  localparam int          QW    = 17 - AW;
  localparam longint      RECIP = ((64'sd1 <<< SH) + STACK_BYTES - 1) / STACK_BYTES;
  localparam logic [17:0] MUL_K = 18'(RECIP);

  logic [33:0]   prod;
  logic [QW-1:0] quot_r;
  logic [15:0]   addr_r;
  logic [15:0]   base;
  logic [15:0]   rem;

  // quotient by reciprocal multiply; exact for every 16-bit address
  assign prod = 34'(addr) * 34'(MUL_K);

  always_ff @(posedge clk) begin
    quot_r <= prod[SH +: QW];
    addr_r <= addr;
  end

  assign base = 16'(32'(quot_r) * 32'(STACK_BYTES));
  assign rem  = addr_r - base;
  assign slot = rem[AW-1:0];

endmodule

/* design/bctu_outq.sv */
// Two-entry result queue between the sequencer and the response channel.
`timescale 1ns / 1ps

module bctu_outq import bctu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  outq_wr_t wr,
  output logic     full,
  output logic     out_valid,
  input  logic     out_ready,
  output rsp_t     out_data
);

  rsp_t       ent_r [2];
  logic       head_r, head_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic       tail;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[head_r];
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && out_ready;
  assign tail      = head_r ^ cnt_r[0];

  always_comb begin
    head_nxt = pop ? ~head_r : head_r;
    cnt_nxt  = 2'(cnt_r + {1'b0, wr.push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      ent_r[tail] <= wr.data;
    end
  end

endmodule

/* design/branch_call_trap_unit_core.sv */
// Top level of the branch/call/trap unit: PC, status word, SP and stack memory.
//
//   channel | dir | handshake     | beat payload
//   in_req  | in  | valid / ready | req_type, target_address, branch_offset
//   out_rsp | out | valid / ready | program_counter_out, status_word_out, stack_pointer_out
//
// Register-only requests push their result as they are accepted and may follow each other
// every cycle while the queue is not full. jsr writes two bytes, ret reads two, trap push
// writes four and trap pop reads four: one byte per cycle on the single stack memory port,
// behind the registered slot calculation and the registered read. After reset a clearing
// pass writes zero to all STACK_BYTES entries, one per cycle, with in_req.ready low.
// in_req.ready is also low while a stack operation runs. Results queue two deep; a full queue also stalls the input.
`timescale 1ns / 1ps

module branch_call_trap_unit_core import bctu_pkg::*; #(
  parameter int STACK_BYTES = BCTU_STACK_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  bctu_req_if.sink   in_req,
  bctu_rsp_if.source out_rsp
);

  localparam int AW = $clog2(STACK_BYTES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(STACK_BYTES - 1);

  seq_state_t  state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [15:0] sw_r, sw_nxt;
  logic [15:0] sp_r, sp_nxt;
  mop_t        op_r, op_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [15:0] base_r, base_nxt;
  logic [15:0] tgt_r, tgt_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [1:0]  rd_step_r, rd_step_nxt;

  logic [15:0] slot_addr;
  logic [AW-1:0] slot;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;
  outq_wr_t    q_wr;
  logic        q_full;
  rsp_t        q_out;
  logic        accept;
  req_t        req;
  logic        taken;

  assign req          = req_t'(in_req.req_type);
  assign in_req.ready = (state_r == ST_IDLE) && !q_full;
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pc_nxt      = pc_r;
    sw_nxt      = sw_r;
    sp_nxt      = sp_r;
    op_nxt      = op_r;
    step_nxt    = step_r;
    base_nxt    = base_r;
    tgt_nxt     = tgt_r;
    lo_nxt      = lo_r;
    rd_pend_nxt = 1'b0;
    rd_step_nxt = rd_step_r;
    ram_we      = 1'b0;
    ram_addr    = slot;
    ram_wdata   = 8'd0;
    q_wr.push   = 1'b0;
    taken       = 1'b0;
    slot_addr   = 16'(base_r + mop_offset(op_r, 2'(step_r + 2'd1)));

    // collect the byte read in the previous cycle
    if (rd_pend_r) begin
      if (!rd_step_r[0]) begin
        lo_nxt = ram_rdata;
      end else if (op_r == MOP_POP && rd_step_r == 2'd1) begin
        sw_nxt = {ram_rdata, lo_r};
      end else begin
        pc_nxt = {ram_rdata, lo_r};
      end
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        clr_cnt_nxt = AW'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        slot_addr = 16'(sp_r + mop_offset(mop_of(req), 2'd0));
        if (accept) begin
          q_wr.push = 1'b1;
          case (req)
            REQ_SET_STATUS: sw_nxt = in_req.target_address;
            REQ_SET_SP:     sp_nxt = in_req.target_address;
            REQ_JMP:        pc_nxt = in_req.target_address;
            REQ_BR:         taken  = 1'b1;
            REQ_BRN:        taken  = (sw_r & FLAG_N) != 16'd0;
            REQ_BRZ:        taken  = (sw_r & FLAG_Z) != 16'd0;
            REQ_BRC:        taken  = (sw_r & FLAG_C) != 16'd0;
            REQ_BRO:        taken  = (sw_r & FLAG_O) != 16'd0;
            REQ_JSR, REQ_RET, REQ_TRAP_PUSH, REQ_TRAP_POP: begin
              q_wr.push = 1'b0;
              op_nxt    = mop_of(req);
              step_nxt  = 2'd0;
              base_nxt  = sp_r;
              tgt_nxt   = in_req.target_address;
              state_nxt = ST_MEM;
            end
            default: ;
          endcase
          if (taken) begin
            pc_nxt = 16'(pc_r + $unsigned(in_req.branch_offset));
          end
        end
      end
      ST_MEM: begin
        if (mop_writes(op_r)) begin
          ram_we = 1'b1;
          case (step_r)
            2'd0:    ram_wdata = pc_r[7:0];
            2'd1:    ram_wdata = pc_r[15:8];
            2'd2:    ram_wdata = sw_r[7:0];
            default: ram_wdata = sw_r[15:8];
          endcase
        end else begin
          rd_pend_nxt = 1'b1;
          rd_step_nxt = step_r;
        end
        if (step_r == mop_last(op_r)) begin
          if (mop_writes(op_r)) begin
            sp_nxt    = 16'(base_r + mop_sp_delta(op_r));
            if (op_r == MOP_JSR) begin
              pc_nxt = tgt_r;
            end
            q_wr.push = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_LAST;
          end
        end else begin
          step_nxt = 2'(step_r + 2'd1);
        end
      end
      ST_LAST: begin
        // final read byte lands now
        sp_nxt    = 16'(base_r + mop_sp_delta(op_r));
        q_wr.push = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    q_wr.data.pc = pc_nxt;
    q_wr.data.sw = sw_nxt;
    q_wr.data.sp = sp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      pc_r      <= 16'd0;
      sw_r      <= 16'd0;
      sp_r      <= 16'd0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pc_r      <= pc_nxt;
      sw_r      <= sw_nxt;
      sp_r      <= sp_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    step_r    <= step_nxt;
    base_r    <= base_nxt;
    tgt_r     <= tgt_nxt;
    lo_r      <= lo_nxt;
    rd_step_r <= rd_step_nxt;
  end

  bctu_slot #(.STACK_BYTES(STACK_BYTES)) u_slot (
    .clk  (clk),
    .addr (slot_addr),
    .slot (slot)
  );

  bctu_ram #(.WIDTH(8), .DEPTH(STACK_BYTES)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bctu_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (q_wr),
    .full      (q_full),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .out_data  (q_out)
  );

  assign out_rsp.program_counter_out = q_out.pc;
  assign out_rsp.status_word_out     = q_out.sw;
  assign out_rsp.stack_pointer_out   = q_out.sp;

endmodule

/* design/bctu_checker.sv */
// Port-level checks of the branch/call/trap unit and their bind to the top level.
`timescale 1ns / 1ps

module bctu_checker import bctu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [3:0]  in_type,
  input logic [15:0] in_target,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pc,
  input logic [15:0] out_sw,
  input logic [15:0] out_sp
);

  logic [2:0] pending_r;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
    end else begin
      pending_r <= 3'(pending_r + {2'd0, in_beat} - {2'd0, out_beat});
    end
  end

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during stack clearing pass");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result beat without a pending request");

  a_bounded_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd2)
    else $error("more requests in flight than the result queue holds");

  a_set_status_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_type == 4'(REQ_SET_STATUS) && pending_r == 3'd0
      |=> out_valid && out_sw == $past(in_target))
    else $error("status load not reflected in next result");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pc) && $stable(out_sw)
      && $stable(out_sp))
    else $error("stalled result beat changed");

endmodule

bind branch_call_trap_unit_core bctu_checker u_bctu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .in_type   (in_req.req_type),
  .in_target (in_req.target_address),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_pc    (out_rsp.program_counter_out),
  .out_sw    (out_rsp.status_word_out),
  .out_sp    (out_rsp.stack_pointer_out)
);
